@@ hw/rtl/mic_pkg.sv @@
package mic_pkg;

  localparam int ELEM_W      = 32;
  localparam int MAX_ORDER   = 4;
  localparam int ORD_W       = 3;
  localparam int POS_W       = 2;
  localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int SLOTS       = 2;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int RAM_DEPTH   = SLOTS * STORE_DEPTH;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);

  // Limb-serial product and wide accumulators
  localparam int LIMB_W      = 32;
  localparam int LIMBS       = 5;
  localparam int PROD_W      = LIMB_W * LIMBS;
  localparam int ACC_W       = 136;
  localparam int FRAC_W      = 16;

  // Rounding divider: quotient bits and widths
  localparam int NUM_SHIFT   = ELEM_W + 1;
  localparam int QBITS       = ELEM_W + 2;
  localparam int QB_W        = $clog2(QBITS);
  localparam int DIV_W       = ACC_W + QBITS;

  typedef struct packed {
    logic              nonempty;
    logic [SLOT_W-1:0] rd_slot;
    logic [ORD_W-1:0]  order;
  } mic_qstat_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [ELEM_W-1:0] data;
  } mic_wrreq_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
  } mic_rdreq_t;

  // Map a written order onto the supported range
  function automatic logic [ORD_W-1:0] clamp_order(input logic [ORD_W-1:0] v);
    logic [ORD_W-1:0] r;
    if (v < ORD_W'(2)) begin
      r = ORD_W'(2);
    end else if (v > ORD_W'(MAX_ORDER)) begin
      r = ORD_W'(MAX_ORDER);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Number of permutation terms of a minor of order m
  function automatic logic [2:0] term_count(input logic [1:0] m);
    logic [2:0] r;
    unique case (m)
      2'd1:    r = 3'd1;
      2'd2:    r = 3'd2;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

  // Column taken by factor k of permutation term t (order m)
  function automatic logic [1:0] perm_col(input logic [1:0] m, input logic [2:0] t,
                                          input logic [1:0] k);
    logic [5:0] p;
    logic [5:0] sh;
    p = 6'd0;
    unique case (m)
      2'd1: p = 6'd0;
      2'd2: p = t[0] ? {2'd0, 2'd0, 2'd1} : {2'd0, 2'd1, 2'd0};
      default: begin
        unique case (t)
          3'd0:    p = {2'd2, 2'd1, 2'd0};
          3'd1:    p = {2'd1, 2'd2, 2'd0};
          3'd2:    p = {2'd2, 2'd0, 2'd1};
          3'd3:    p = {2'd0, 2'd2, 2'd1};
          3'd4:    p = {2'd1, 2'd0, 2'd2};
          default: p = {2'd0, 2'd1, 2'd2};
        endcase
      end
    endcase
    sh = p >> {k, 1'b0};
    return sh[1:0];
  endfunction

  // Parity of permutation term t (1 = odd)
  function automatic logic perm_sign(input logic [1:0] m, input logic [2:0] t);
    logic r;
    unique case (m)
      2'd1:    r = 1'b0;
      2'd2:    r = t[0];
      default: r = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/matrix_inverse_cofactor.sv @@
// The first result follows the determinant and one cofactor.
// The shared 32x32 limb multiplier and the one-bit-per-cycle rounding divider serve one matrix
//   at a time; input takes one element per cycle while a slot is free, two slots.
// Reset: synchronous active-low rst_n clears the load count and queue, order returns to 4.
module matrix_inverse_cofactor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [mic_pkg::ELEM_W-1:0] in_element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mic_pkg::ELEM_W-1:0] out_inverse_value,
  output logic [mic_pkg::POS_W-1:0]         out_row,
  output logic [mic_pkg::POS_W-1:0]         out_col,
  output logic signed [mic_pkg::ELEM_W-1:0] out_det_value,
  output logic                              out_is_singular,
  output logic                              out_was_saturated,
  output logic                              out_is_last,
  input  logic                              cfg_wr_en,
  input  logic [mic_pkg::ORD_W-1:0]         cfg_wr_data
);
  import mic_pkg::*;

  mic_qstat_t        qstat;
  mic_wrreq_t        wrreq;
  mic_rdreq_t        rdreq;
  logic              pop;
  logic [ELEM_W-1:0] rd_data;

  // Loader and slot queue
  mic_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .pop_i            (pop),
    .qstat_o          (qstat),
    .wrreq_o          (wrreq)
  );

  // Element store, two matrix slots
  mic_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wrreq.en),
    .wr_addr (wrreq.addr),
    .wr_data (wrreq.data),
    .rd_en   (rdreq.en),
    .rd_addr (rdreq.addr),
    .rd_data (rd_data)
  );

  // Cofactor, determinant and division engine
  mic_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .qstat_i           (qstat),
    .pop_o             (pop),
    .rdreq_o           (rdreq),
    .rd_data_i         (rd_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_inverse_value (out_inverse_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_det_value     (out_det_value),
    .out_is_singular   (out_is_singular),
    .out_was_saturated (out_was_saturated),
    .out_is_last       (out_is_last)
  );

endmodule

@@ hw/rtl/mic_ram.sv @@
module mic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

@@ hw/rtl/mic_front.sv @@
module mic_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mic_pkg::ELEM_W-1:0]   in_element_value,
  input  logic                         cfg_wr_en,
  input  logic [mic_pkg::ORD_W-1:0]    cfg_wr_data,
  input  logic                         pop_i,
  output mic_pkg::mic_qstat_t          qstat_o,
  output mic_pkg::mic_wrreq_t          wrreq_o
);
  import mic_pkg::*;

  logic [ORD_W-1:0]  order_r, order_nxt;
  logic [IDX_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ORD_W-1:0]  slot_order_r [SLOTS];
  logic [2*ORD_W-1:0] order_sq;
  logic [IDX_W-1:0]  last_idx;
  logic              accept;
  logic              push;

  assign in_ready = (count_r != CNT_W'(SLOTS));
  assign accept   = in_valid && in_ready;
  assign order_sq = order_r * order_r;
  assign last_idx = IDX_W'(order_sq - 1'b1);
  assign push     = accept && (load_cnt_r == last_idx);

  // Store each element into the slot being filled
  assign wrreq_o.en   = accept;
  assign wrreq_o.addr = {wr_slot_r, load_cnt_r};
  assign wrreq_o.data = in_element_value;

  assign qstat_o.nonempty = (count_r != '0);
  assign qstat_o.rd_slot  = rd_slot_r;
  assign qstat_o.order    = slot_order_r[rd_slot_r];

  // Load counter, order register and slot bookkeeping
  always_comb begin
    order_nxt    = order_r;
    load_cnt_nxt = load_cnt_r;
    wr_slot_nxt  = wr_slot_r;
    rd_slot_nxt  = rd_slot_r;
    count_nxt    = count_r;
    if (cfg_wr_en) begin
      order_nxt    = clamp_order(cfg_wr_data);
      load_cnt_nxt = '0;
    end else if (accept) begin
      if (push) begin
        load_cnt_nxt = '0;
        wr_slot_nxt  = wr_slot_r + 1'b1;
      end else begin
        load_cnt_nxt = load_cnt_r + 1'b1;
      end
    end
    if (pop_i) begin
      rd_slot_nxt = rd_slot_r + 1'b1;
    end
    if (push && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r    <= ORD_W'(MAX_ORDER);
      load_cnt_r <= '0;
      wr_slot_r  <= '0;
      rd_slot_r  <= '0;
      count_r    <= '0;
    end else begin
      order_r    <= order_nxt;
      load_cnt_r <= load_cnt_nxt;
      wr_slot_r  <= wr_slot_nxt;
      rd_slot_r  <= rd_slot_nxt;
      count_r    <= count_nxt;
    end
  end

  // Tag a completed slot with its order
  always_ff @(posedge clk) begin
    if (push) begin
      slot_order_r[wr_slot_r] <= order_r;
    end
  end

endmodule

@@ hw/rtl/mic_back.sv @@
module mic_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mic_pkg::mic_qstat_t               qstat_i,
  output logic                              pop_o,
  output mic_pkg::mic_rdreq_t               rdreq_o,
  input  logic [mic_pkg::ELEM_W-1:0]        rd_data_i,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mic_pkg::ELEM_W-1:0] out_inverse_value,
  output logic [mic_pkg::POS_W-1:0]         out_row,
  output logic [mic_pkg::POS_W-1:0]         out_col,
  output logic signed [mic_pkg::ELEM_W-1:0] out_det_value,
  output logic                              out_is_singular,
  output logic                              out_was_saturated,
  output logic                              out_is_last
);
  import mic_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_COF  = 5'd1;
  localparam logic [4:0] ST_TERM = 5'd2;
  localparam logic [4:0] ST_RD   = 5'd3;
  localparam logic [4:0] ST_GET  = 5'd4;
  localparam logic [4:0] ST_MUL  = 5'd5;
  localparam logic [4:0] ST_TEND = 5'd6;
  localparam logic [4:0] ST_CEND = 5'd7;
  localparam logic [4:0] ST_DRD  = 5'd8;
  localparam logic [4:0] ST_DGET = 5'd9;
  localparam logic [4:0] ST_DADD = 5'd10;
  localparam logic [4:0] ST_DABS = 5'd11;
  localparam logic [4:0] ST_DQ   = 5'd12;
  localparam logic [4:0] ST_DINI = 5'd13;
  localparam logic [4:0] ST_DIV  = 5'd14;
  localparam logic [4:0] ST_DFIN = 5'd15;
  localparam logic [4:0] ST_ZERO = 5'd16;
  localparam logic [4:0] ST_EMIT = 5'd17;

  localparam logic [ELEM_W-1:0] POS_LIM = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] NEG_LIM = {1'b1, {(ELEM_W-1){1'b0}}};

  logic [4:0]        state_r, state_nxt;
  logic              phase_det_r, phase_det_nxt;
  logic [ORD_W-1:0]  n_r, n_nxt;
  logic [POS_W-1:0]  r_r, r_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [2:0]        t_r, t_nxt;
  logic [1:0]        k_r, k_nxt;
  logic              tsign_r, tsign_nxt;
  logic [LIMB_W-1:0] m_r, m_nxt;
  logic [2:0]        mk_r, mk_nxt, nl_r, nl_nxt;
  logic [LIMB_W-1:0] carry_r, carry_nxt;
  logic              det_mul_r, det_mul_nxt;
  logic [LIMB_W-1:0] pr_r [LIMBS];
  logic [LIMB_W-1:0] pr_nxt [LIMBS];
  logic [ACC_W-1:0]  acc_r, acc_nxt, det_r, det_nxt;
  logic [ACC_W-1:0]  cof_abs_r, cof_abs_nxt, dabs_r, dabs_nxt;
  logic              cneg_r, cneg_nxt, det_neg_r, det_neg_nxt;
  logic              singular_r, singular_nxt, det_sat_r, det_sat_nxt;
  logic [ELEM_W-1:0] detq_r, detq_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [QBITS-1:0]  q_r, q_nxt;
  logic [QB_W-1:0]   bit_r, bit_nxt;
  logic              neg_r, neg_nxt;
  logic [ELEM_W-1:0] ov_r, ov_nxt;
  logic [POS_W-1:0]  orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic              osat_r, osat_nxt, olast_r, olast_nxt;

  logic [1:0]        ord_m;
  logic [POS_W-1:0]  last_pos, rr, cc, pcol, frow, fcol;
  logic [ORD_W+POS_W-1:0] colbase;
  logic [IDX_W-1:0]  idx;
  logic [2:0]        t_last;
  logic [PROD_W-1:0] pflat, cof_ext;
  logic [ACC_W-1:0]  pacc;
  logic [ELEM_W-1:0] emag;
  logic [2*LIMB_W-1:0] prod;
  logic [6:0]        shamt;
  logic [ACC_W:0]    half, dq_sum, dq_q, dq_lim;
  logic              dq_big;
  logic [ELEM_W-1:0] dq_mag;
  logic [DIV_W:0]    diff;
  logic              ge;
  logic [QBITS-1:0]  qlim;
  logic              qbig;
  logic [ELEM_W-1:0] qmag;
  logic              at_last;

  // Indexing of the minor being expanded
  assign ord_m    = 2'(n_r - 3'd1);
  assign last_pos = 2'(n_r - 3'd1);
  assign rr       = phase_det_r ? r_r : j_r;
  assign cc       = phase_det_r ? 2'd0 : i_r;
  assign pcol     = perm_col(ord_m, t_r, k_r);
  assign frow     = (k_r >= rr) ? k_r + 2'd1 : k_r;
  assign fcol     = (pcol >= cc) ? pcol + 2'd1 : pcol;
  assign colbase  = fcol * n_r;
  assign idx      = IDX_W'(colbase + (ORD_W+POS_W)'(frow));
  assign t_last   = term_count(ord_m) - 3'd1;
  assign at_last  = (i_r == last_pos) && (j_r == last_pos);

  always_comb begin
    for (int l = 0; l < LIMBS; l++) begin
      pflat[l*LIMB_W +: LIMB_W] = pr_r[l];
    end
  end
  assign pacc    = pflat[ACC_W-1:0];
  assign cof_ext = PROD_W'(cof_abs_r);
  assign emag    = rd_data_i[ELEM_W-1] ? ELEM_W'(0 - rd_data_i) : rd_data_i;
  assign prod    = pr_r[mk_r] * m_r + (2*LIMB_W)'(carry_r);

  // Determinant rounding by a power-of-two shift
  assign shamt  = {n_r - 3'd1, 4'd0};
  assign half   = (ACC_W+1)'(1) << (shamt - 7'd1);
  assign dq_sum = {1'b0, dabs_r} + half;
  assign dq_q   = dq_sum >> shamt;
  assign dq_lim = (ACC_W+1)'(det_neg_r ? NEG_LIM : POS_LIM);
  assign dq_big = dq_q > dq_lim;
  assign dq_mag = dq_big ? dq_lim[ELEM_W-1:0] : dq_q[ELEM_W-1:0];

  // One restoring division step, and the final saturation
  assign diff = {1'b0, rem_r} - {1'b0, dsh_r};
  assign ge   = !diff[DIV_W];
  assign qlim = QBITS'(neg_r ? NEG_LIM : POS_LIM);
  assign qbig = q_r > qlim;
  assign qmag = qbig ? qlim[ELEM_W-1:0] : q_r[ELEM_W-1:0];

  assign pop_o     = (state_r == ST_EMIT) && out_ready && at_last;
  assign out_valid = (state_r == ST_EMIT);

  always_comb begin
    rdreq_o.en   = 1'b0;
    rdreq_o.addr = {qstat_i.rd_slot, idx};
    if (state_r == ST_RD) begin
      rdreq_o.en = 1'b1;
    end else if (state_r == ST_DRD) begin
      rdreq_o.en   = 1'b1;
      rdreq_o.addr = {qstat_i.rd_slot, IDX_W'(r_r)};
    end
  end

  // Sequencer: cofactors, determinant, division, emit
  always_comb begin
    state_nxt     = state_r;
    phase_det_nxt = phase_det_r;
    n_nxt         = n_r;
    r_nxt         = r_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    t_nxt         = t_r;
    k_nxt         = k_r;
    tsign_nxt     = tsign_r;
    m_nxt         = m_r;
    mk_nxt        = mk_r;
    nl_nxt        = nl_r;
    carry_nxt     = carry_r;
    det_mul_nxt   = det_mul_r;
    pr_nxt        = pr_r;
    acc_nxt       = acc_r;
    det_nxt       = det_r;
    cof_abs_nxt   = cof_abs_r;
    cneg_nxt      = cneg_r;
    dabs_nxt      = dabs_r;
    det_neg_nxt   = det_neg_r;
    singular_nxt  = singular_r;
    det_sat_nxt   = det_sat_r;
    detq_nxt      = detq_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    neg_nxt       = neg_r;
    ov_nxt        = ov_r;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    osat_nxt      = osat_r;
    olast_nxt     = olast_r;
    unique case (state_r)
      ST_IDLE: begin
        if (qstat_i.nonempty) begin
          n_nxt         = qstat_i.order;
          phase_det_nxt = 1'b1;
          r_nxt         = '0;
          det_nxt       = '0;
          state_nxt     = ST_COF;
        end
      end
      ST_COF: begin
        acc_nxt   = '0;
        t_nxt     = '0;
        state_nxt = ST_TERM;
      end
      ST_TERM: begin
        k_nxt     = '0;
        tsign_nxt = perm_sign(ord_m, t_r) ^ rr[0] ^ cc[0];
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_GET;
      end
      ST_GET: begin
        tsign_nxt = tsign_r ^ rd_data_i[ELEM_W-1];
        if (k_r == 2'd0) begin
          for (int l = 0; l < LIMBS; l++) begin
            pr_nxt[l] = '0;
          end
          pr_nxt[0] = emag;
          if (k_r == ord_m - 2'd1) begin
            state_nxt = ST_TEND;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_RD;
          end
        end else begin
          m_nxt       = emag;
          mk_nxt      = '0;
          carry_nxt   = '0;
          nl_nxt      = 3'(k_r);
          det_mul_nxt = 1'b0;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        pr_nxt[mk_r] = prod[LIMB_W-1:0];
        carry_nxt    = prod[2*LIMB_W-1:LIMB_W];
        if (mk_r == nl_r) begin
          if (det_mul_r) begin
            state_nxt = ST_DADD;
          end else if (k_r == ord_m - 2'd1) begin
            state_nxt = ST_TEND;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_RD;
          end
        end else begin
          mk_nxt = mk_r + 3'd1;
        end
      end
      ST_TEND: begin
        acc_nxt = tsign_r ? acc_r - pacc : acc_r + pacc;
        if (t_r == t_last) begin
          state_nxt = ST_CEND;
        end else begin
          t_nxt     = t_r + 3'd1;
          state_nxt = ST_TERM;
        end
      end
      ST_CEND: begin
        cneg_nxt    = acc_r[ACC_W-1];
        cof_abs_nxt = acc_r[ACC_W-1] ? ACC_W'(0 - acc_r) : acc_r;
        state_nxt   = phase_det_r ? ST_DRD : ST_DINI;
      end
      ST_DRD: begin
        for (int l = 0; l < LIMBS; l++) begin
          pr_nxt[l] = (l == LIMBS - 1) ? '0 : cof_ext[l*LIMB_W +: LIMB_W];
        end
        tsign_nxt = cneg_r;
        state_nxt = ST_DGET;
      end
      ST_DGET: begin
        tsign_nxt   = tsign_r ^ rd_data_i[ELEM_W-1];
        m_nxt       = emag;
        mk_nxt      = '0;
        carry_nxt   = '0;
        nl_nxt      = 3'(LIMBS - 1);
        det_mul_nxt = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_DADD: begin
        det_nxt = tsign_r ? det_r - pacc : det_r + pacc;
        if (r_r == last_pos) begin
          state_nxt = ST_DABS;
        end else begin
          r_nxt     = r_r + 2'd1;
          state_nxt = ST_COF;
        end
      end
      ST_DABS: begin
        singular_nxt = (det_r == '0);
        det_neg_nxt  = det_r[ACC_W-1];
        dabs_nxt     = det_r[ACC_W-1] ? ACC_W'(0 - det_r) : det_r;
        state_nxt    = ST_DQ;
      end
      ST_DQ: begin
        phase_det_nxt = 1'b0;
        i_nxt         = '0;
        j_nxt         = '0;
        if (singular_r) begin
          detq_nxt    = '0;
          det_sat_nxt = 1'b0;
          state_nxt   = ST_ZERO;
        end else begin
          detq_nxt    = det_neg_r ? ELEM_W'(0 - dq_mag) : dq_mag;
          det_sat_nxt = dq_big;
          state_nxt   = ST_COF;
        end
      end
      ST_DINI: begin
        rem_nxt   = (DIV_W'(cof_abs_r) << NUM_SHIFT) + DIV_W'(dabs_r);
        dsh_nxt   = DIV_W'(dabs_r) << QBITS;
        q_nxt     = '0;
        bit_nxt   = QB_W'(QBITS - 1);
        neg_nxt   = cneg_r ^ det_neg_r;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (ge) begin
          rem_nxt = diff[DIV_W-1:0];
        end
        q_nxt   = {q_r[QBITS-2:0], ge};
        dsh_nxt = dsh_r >> 1;
        if (bit_r == '0) begin
          state_nxt = ST_DFIN;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      ST_DFIN: begin
        ov_nxt    = neg_r ? ELEM_W'(0 - qmag) : qmag;
        osat_nxt  = qbig || det_sat_r;
        orow_nxt  = i_r;
        ocol_nxt  = j_r;
        olast_nxt = at_last;
        state_nxt = ST_EMIT;
      end
      ST_ZERO: begin
        ov_nxt    = '0;
        osat_nxt  = 1'b0;
        orow_nxt  = i_r;
        ocol_nxt  = j_r;
        olast_nxt = at_last;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (at_last) begin
            state_nxt = ST_IDLE;
          end else begin
            if (i_r == last_pos) begin
              i_nxt = '0;
              j_nxt = j_r + 2'd1;
            end else begin
              i_nxt = i_r + 2'd1;
            end
            state_nxt = singular_r ? ST_ZERO : ST_COF;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers hold their value unless the sequencer updates them
  always_ff @(posedge clk) begin
    phase_det_r <= phase_det_nxt;
    n_r         <= n_nxt;
    r_r         <= r_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    t_r         <= t_nxt;
    k_r         <= k_nxt;
    tsign_r     <= tsign_nxt;
    m_r         <= m_nxt;
    mk_r        <= mk_nxt;
    nl_r        <= nl_nxt;
    carry_r     <= carry_nxt;
    det_mul_r   <= det_mul_nxt;
    pr_r        <= pr_nxt;
    acc_r       <= acc_nxt;
    det_r       <= det_nxt;
    cof_abs_r   <= cof_abs_nxt;
    cneg_r      <= cneg_nxt;
    dabs_r      <= dabs_nxt;
    det_neg_r   <= det_neg_nxt;
    singular_r  <= singular_nxt;
    det_sat_r   <= det_sat_nxt;
    detq_r      <= detq_nxt;
    rem_r       <= rem_nxt;
    dsh_r       <= dsh_nxt;
    q_r         <= q_nxt;
    bit_r       <= bit_nxt;
    neg_r       <= neg_nxt;
    ov_r        <= ov_nxt;
    orow_r      <= orow_nxt;
    ocol_r      <= ocol_nxt;
    osat_r      <= osat_nxt;
    olast_r     <= olast_nxt;
  end

  assign out_inverse_value = $signed(ov_r);
  assign out_row           = orow_r;
  assign out_col           = ocol_r;
  assign out_det_value     = $signed(detq_r);
  assign out_is_singular   = singular_r;
  assign out_was_saturated = osat_r;
  assign out_is_last       = olast_r;

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |-> qstat_i.nonempty)
    else $error("slot released with empty queue");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_singular |-> (out_inverse_value == '0) && !out_was_saturated)
    else $error("singular matrix produced nonzero entry");

  a_limb_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (mk_r <= nl_r))
    else $error("multiplier limb index out of range");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dabs_r != '0))
    else $error("divider running on zero determinant");

endmodule
